### rtl/ssaa_pkg.sv
// shared types and constants of the supersample antialias downsampler
`timescale 1ns / 1ps

package ssaa_pkg;

  localparam int NPIX     = 9;
  localparam int NCHAN    = 3;
  localparam int PIX_W    = 24;
  localparam int CHAN_W   = 8;
  localparam int CNT_W    = 4;   // weight counts, at most 15
  localparam int D_W      = 6;   // divisor bgc + 4*fgc, at most 60
  localparam int SUM_W    = 12;  // weighted channel sum, at most 15*255
  localparam int NUM_W    = 14;  // 4*sum + bgc*bg, at most 60*255
  localparam int DIV_BITS = CHAN_W;

  // pipeline stage numbers
  localparam int ST_CLASS = 0;
  localparam int ST_SUM   = 1;
  localparam int ST_DIV0  = 2;
  localparam int ST_MERGE = ST_DIV0 + DIV_BITS;
  localparam int NSTAGE   = ST_MERGE + 1;

  // configuration register indexes
  localparam logic REG_BACKGROUND = 1'b0;
  localparam logic REG_BLUR       = 1'b1;

  localparam logic [PIX_W-1:0] NEAR_MASK = 24'hFCFCFC;
  localparam logic [CNT_W-1:0] WEIGHT_TOTAL = 4'd15;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // tent kernel 1,2,1 / 2,3,2 / 1,2,1
  localparam logic [1:0] KERNEL_W [NPIX] = '{2'd1, 2'd2, 2'd1,
                                             2'd2, 2'd3, 2'd2,
                                             2'd1, 2'd2, 2'd1};

  typedef struct packed {
    logic fg_none;
    logic plain;
    logic blur;
  } ctrl_t;

endpackage

### rtl/supersample_antialias_downsample_core.sv
// top level of the 2x supersample antialias downsampler
`timescale 1ns / 1ps

// Usage: each input request carries the nine 24-bit pixels of one 3x3
// supersampled window plus the current destination pixel; each output
// request carries one antialiased 0xRRGGBB pixel. Both channels use
// valid/ready; results come out in request order, one per input.
// Configuration (background key, blur enable) is written through
// cfg_wen/cfg_index/cfg_data and should only change while the block is empty.
// From input acceptance to out_valid there is one compare and count stage,
// one weighted-sum stage, eight restoring divider stages (one quotient bit
// each, one divider per color lane) and one merge stage that also serves as
// the output register. Throughput is one pixel per clock while out_ready
// is high. When the receiver stalls, items pile up stage by stage; the input
// keeps being accepted until every stage is full, so ready drops only then.
// Reset clears all stage valid bits and both configuration registers.
module supersample_antialias_downsample_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic                  cfg_index,
  input  logic [23:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ssaa_pkg::pix_t        top_left,
  input  ssaa_pkg::pix_t        top_mid,
  input  ssaa_pkg::pix_t        top_right,
  input  ssaa_pkg::pix_t        mid_left,
  input  ssaa_pkg::pix_t        centre,
  input  ssaa_pkg::pix_t        mid_right,
  input  ssaa_pkg::pix_t        bot_left,
  input  ssaa_pkg::pix_t        bot_mid,
  input  ssaa_pkg::pix_t        bot_right,
  input  ssaa_pkg::pix_t        previous_out,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssaa_pkg::pix_t        out_colour
);
  import ssaa_pkg::*;

  pix_t background_colour;
  logic blur_enable;

  logic [NSTAGE-1:0] valid_s;
  logic [NSTAGE-1:0] adv;

  pix_t             win   [NPIX];
  pix_t             win_r [NPIX];
  pix_t             prev_r;
  pix_t             bg_r;
  logic [NPIX-1:0]  mask_r;
  logic [CNT_W-1:0] bgc_r;
  logic [D_W-1:0]   d_r;
  ctrl_t            ctrl_0;
  ctrl_t            ctrl_s [ST_SUM:ST_MERGE-1];

  chan_t lane_quo  [NCHAN];
  chan_t lane_bg   [NCHAN];
  chan_t lane_prev [NCHAN];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      background_colour <= '0;
      blur_enable       <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BACKGROUND: background_colour <= cfg_data;
        REG_BLUR:       blur_enable       <= cfg_data[0];
      endcase
    end
  end

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[NSTAGE-1] = !valid_s[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !valid_s[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[ST_CLASS];
  assign out_valid = valid_s[ST_MERGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s <= '0;
    end else begin
      if (adv[ST_CLASS]) begin
        valid_s[ST_CLASS] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          valid_s[k] <= valid_s[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      ctrl_s[ST_SUM] <= ctrl_0;
    end
    for (int k = ST_SUM + 1; k < ST_MERGE; k++) begin
      if (adv[k]) begin
        ctrl_s[k] <= ctrl_s[k-1];
      end
    end
  end

  assign win[0] = top_left;
  assign win[1] = top_mid;
  assign win[2] = top_right;
  assign win[3] = mid_left;
  assign win[4] = centre;
  assign win[5] = mid_right;
  assign win[6] = bot_left;
  assign win[7] = bot_mid;
  assign win[8] = bot_right;

  ssaa_classify u_classify (
    .clk    (clk),
    .en     (adv[ST_CLASS]),
    .win    (win),
    .prev   (previous_out),
    .bg     (background_colour),
    .blur   (blur_enable),
    .win_r  (win_r),
    .prev_r (prev_r),
    .bg_r   (bg_r),
    .mask_r (mask_r),
    .bgc_r  (bgc_r),
    .d_r    (d_r),
    .ctrl_r (ctrl_0)
  );

  for (genvar c = 0; c < NCHAN; c++) begin : g_lane
    chan_t pix_c [NPIX];

    always_comb begin
      for (int i = 0; i < NPIX; i++) begin
        pix_c[i] = win_r[i][c*CHAN_W +: CHAN_W];
      end
    end

    ssaa_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .pix_c  (pix_c),
      .mask   (mask_r),
      .bgc    (bgc_r),
      .d      (d_r),
      .bg_c   (bg_r[c*CHAN_W +: CHAN_W]),
      .prev_c (prev_r[c*CHAN_W +: CHAN_W]),
      .quo    (lane_quo[c]),
      .bg_q   (lane_bg[c]),
      .prev_q (lane_prev[c])
    );
  end

  ssaa_merge u_merge (
    .clk        (clk),
    .en         (adv[ST_MERGE]),
    .ctrl       (ctrl_s[ST_MERGE-1]),
    .quo        (lane_quo),
    .bg_c       (lane_bg),
    .prev_c     (lane_prev),
    .out_colour (out_colour)
  );

  a_empty_front_ready: assert property (@(posedge clk) disable iff (rst)
    !valid_s[ST_CLASS] |-> in_ready)
    else $error("front stage empty but input not ready");

  a_accept_fills_front: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid_s[ST_CLASS])
    else $error("accepted request did not enter the pipeline");

  a_stalled_out_kept: assert property (@(posedge clk) disable iff (rst)
    valid_s[ST_MERGE] && !out_ready |=> valid_s[ST_MERGE])
    else $error("stalled result dropped");

  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(valid_s[ST_MERGE]) |-> $past(valid_s[ST_MERGE-1]))
    else $error("result appeared without a divider item");

endmodule

### rtl/ssaa_classify.sv
// first stage: background key compare, weight counts and divisor
`timescale 1ns / 1ps

module ssaa_classify (
  input  logic                      clk,
  input  logic                      en,
  input  ssaa_pkg::pix_t            win [ssaa_pkg::NPIX],
  input  ssaa_pkg::pix_t            prev,
  input  ssaa_pkg::pix_t            bg,
  input  logic                      blur,
  output ssaa_pkg::pix_t            win_r [ssaa_pkg::NPIX],
  output ssaa_pkg::pix_t            prev_r,
  output ssaa_pkg::pix_t            bg_r,
  output logic [ssaa_pkg::NPIX-1:0] mask_r,
  output logic [ssaa_pkg::CNT_W-1:0] bgc_r,
  output logic [ssaa_pkg::D_W-1:0]  d_r,
  output ssaa_pkg::ctrl_t           ctrl_r
);
  import ssaa_pkg::*;

  logic [NPIX-1:0]  mask;
  logic [CNT_W-1:0] bgc;
  logic [CNT_W-1:0] fgc;
  logic [D_W-1:0]   d;
  ctrl_t            ctrl;

  always_comb begin
    bgc = '0;
    for (int i = 0; i < NPIX; i++) begin
      mask[i] = (win[i] == bg);
      if (mask[i]) begin
        bgc = bgc + CNT_W'(KERNEL_W[i]);
      end
    end
    fgc = WEIGHT_TOTAL - bgc;
    d = D_W'(bgc) + {fgc, 2'b00};
    ctrl.fg_none = &mask;
    ctrl.blur = blur;
    ctrl.plain = !blur || (((prev ^ bg) & NEAR_MASK) == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPIX; i++) begin
        win_r[i] <= win[i];
      end
      prev_r <= prev;
      bg_r   <= bg;
      mask_r <= mask;
      bgc_r  <= bgc;
      d_r    <= d;
      ctrl_r <= ctrl;
    end
  end

endmodule

### rtl/ssaa_lane.sv
// one color channel: weighted sum, then a bit-per-stage restoring divider
`timescale 1ns / 1ps

module ssaa_lane (
  input  logic                       clk,
  input  logic [ssaa_pkg::NSTAGE-1:0] en,
  input  ssaa_pkg::chan_t            pix_c [ssaa_pkg::NPIX],
  input  logic [ssaa_pkg::NPIX-1:0]  mask,
  input  logic [ssaa_pkg::CNT_W-1:0] bgc,
  input  logic [ssaa_pkg::D_W-1:0]   d,
  input  ssaa_pkg::chan_t            bg_c,
  input  ssaa_pkg::chan_t            prev_c,
  output ssaa_pkg::chan_t            quo,
  output ssaa_pkg::chan_t            bg_q,
  output ssaa_pkg::chan_t            prev_q
);
  import ssaa_pkg::*;

  logic [SUM_W-1:0] acc;
  logic [NUM_W-1:0] num;

  logic [NUM_W-1:0]    rem_s  [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_s  [DIV_BITS+1];
  logic [D_W-1:0]      d_s    [DIV_BITS+1];
  chan_t               bg_s   [DIV_BITS+1];
  chan_t               prev_s [DIV_BITS+1];

  always_comb begin
    acc = '0;
    for (int i = 0; i < NPIX; i++) begin
      if (!mask[i]) begin
        acc = acc + SUM_W'(KERNEL_W[i]) * SUM_W'(pix_c[i]);
      end
    end
    num = {acc, 2'b00} + NUM_W'(bgc) * NUM_W'(bg_c);
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      rem_s[0]  <= num;
      quo_s[0]  <= '0;
      d_s[0]    <= d;
      bg_s[0]   <= bg_c;
      prev_s[0] <= prev_c;
    end
  end

  // quotient never exceeds 255, so eight trial subtracts settle it
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    localparam logic [DIV_BITS-1:0] BIT_M = DIV_BITS'(1) << B;
    logic [NUM_W:0] trial;

    assign trial = {1'b0, rem_s[j]} - ((NUM_W + 1)'(d_s[j]) << B);

    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + j]) begin
        if (!trial[NUM_W]) begin
          rem_s[j+1] <= trial[NUM_W-1:0];
          quo_s[j+1] <= quo_s[j] | BIT_M;
        end else begin
          rem_s[j+1] <= rem_s[j];
          quo_s[j+1] <= quo_s[j];
        end
        d_s[j+1]    <= d_s[j];
        bg_s[j+1]   <= bg_s[j];
        prev_s[j+1] <= prev_s[j];
      end
    end
  end

  assign quo    = quo_s[DIV_BITS];
  assign bg_q   = bg_s[DIV_BITS];
  assign prev_q = prev_s[DIV_BITS];

endmodule

### rtl/ssaa_merge.sv
// final stage: picks plain, blended or background value per channel and packs
`timescale 1ns / 1ps

module ssaa_merge (
  input  logic            clk,
  input  logic            en,
  input  ssaa_pkg::ctrl_t ctrl,
  input  ssaa_pkg::chan_t quo    [ssaa_pkg::NCHAN],
  input  ssaa_pkg::chan_t bg_c   [ssaa_pkg::NCHAN],
  input  ssaa_pkg::chan_t prev_c [ssaa_pkg::NCHAN],
  output ssaa_pkg::pix_t  out_colour
);
  import ssaa_pkg::*;

  pix_t colour_next;

  always_comb begin
    colour_next = '0;
    for (int c = 0; c < NCHAN; c++) begin
      if (ctrl.fg_none) begin
        if (ctrl.blur) begin
          colour_next[c*CHAN_W +: CHAN_W] = {1'b0, prev_c[c][CHAN_W-1:1]}
                                          + {1'b0, bg_c[c][CHAN_W-1:1]};
        end else begin
          colour_next[c*CHAN_W +: CHAN_W] = bg_c[c];
        end
      end else if (ctrl.plain) begin
        colour_next[c*CHAN_W +: CHAN_W] = quo[c];
      end else begin
        // floor(q/2) equals num / (2*d)
        colour_next[c*CHAN_W +: CHAN_W] = {1'b0, prev_c[c][CHAN_W-1:1]}
                                        + {1'b0, quo[c][CHAN_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_colour <= colour_next;
    end
  end

endmodule

### bench/ssaa_checker.sv
// checker for the antialias downsampler: predicts each output pixel and compares
`timescale 1ns / 1ps

module ssaa_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic cfg_index,
  input  logic [23:0] cfg_data,
  input  logic in_valid,
  input  logic in_ready,
  input  ssaa_pkg::pix_t top_left,
  input  ssaa_pkg::pix_t top_mid,
  input  ssaa_pkg::pix_t top_right,
  input  ssaa_pkg::pix_t mid_left,
  input  ssaa_pkg::pix_t centre,
  input  ssaa_pkg::pix_t mid_right,
  input  ssaa_pkg::pix_t bot_left,
  input  ssaa_pkg::pix_t bot_mid,
  input  ssaa_pkg::pix_t bot_right,
  input  ssaa_pkg::pix_t previous_out,
  input  logic out_valid,
  input  logic out_ready,
  input  ssaa_pkg::pix_t out_colour,
  output int fail_count,
  output int pending,
  output int checked,
  output int n_bg_only,
  output int n_plain,
  output int n_blurred
);
  import ssaa_pkg::*;

  typedef enum int {BG_ONLY, PLAIN_MIX, BLUR_MIX} blend_kind_e;

  localparam int unsigned TENT [9] = '{1, 2, 1, 2, 3, 2, 1, 2, 1};
  localparam pix_t HALF_KEEP = 24'hFEFEFE;
  localparam pix_t NEAR_KEEP = 24'hFCFCFC;

  pix_t key_colour;
  bit   blur_on;
  pix_t due_colours [$];
  int   errs;
  int   seen;
  int   kind_hits [3];

  function automatic pix_t antialias_pixel(input pix_t px [9], input pix_t prev,
                                           input pix_t key, input bit blur,
                                           output blend_kind_e kind);
    int unsigned bg_w;
    int unsigned fg_w;
    int unsigned sum [3];
    int unsigned d;
    int unsigned num;
    int unsigned v;
    logic [24:0] avg;
    pix_t res;
    bit plain;
    int i;
    int c;
    bg_w = 0;
    fg_w = 0;
    sum = '{0, 0, 0};
    res = '0;
    for (i = 0; i < 9; i++) begin
      if (px[i] == key) begin
        bg_w += TENT[i];
      end else begin
        for (c = 0; c < 3; c++) sum[c] += TENT[i] * px[i][8*c +: 8];
        fg_w += TENT[i];
      end
    end
    if (fg_w == 0) begin
      kind = BG_ONLY;
      if (blur) begin
        avg = ({1'b0, prev & HALF_KEEP} + {1'b0, key & HALF_KEEP}) >> 1;
        res = avg[23:0];
      end else begin
        res = key;
      end
    end else begin
      d = bg_w + 4 * fg_w;
      // blur off, or old pixel close to the key on every channel: no blur mixing
      plain = !blur || (((prev ^ key) & NEAR_KEEP) == '0);
      kind = plain ? PLAIN_MIX : BLUR_MIX;
      for (c = 0; c < 3; c++) begin
        num = 4 * sum[c] + bg_w * key[8*c +: 8];
        if (plain) v = num / d;
        else v = (prev[8*c +: 8] >> 1) + num / (2 * d);
        res[8*c +: 8] = v[7:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pix_t px [9];
    pix_t want;
    blend_kind_e kind;
    if (rst) begin
      key_colour = '0;
      blur_on = 1'b0;
      due_colours.delete();
      errs = 0;
      seen = 0;
      kind_hits = '{0, 0, 0};
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_BACKGROUND) key_colour = cfg_data;
        else blur_on = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        seen++;
        if (due_colours.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("output pixel %0d with no request outstanding: %06h", seen, out_colour);
        end else begin
          want = due_colours.pop_front();
          if (out_colour !== want) begin
            errs++;
            if (errs <= 10)
              $display("mismatch on pixel %0d: expected %06h got %06h", seen, want,
                       out_colour);
          end
        end
      end
      if (in_valid && in_ready) begin
        px = '{top_left, top_mid, top_right, mid_left, centre, mid_right,
               bot_left, bot_mid, bot_right};
        due_colours.push_back(antialias_pixel(px, previous_out, key_colour, blur_on, kind));
        kind_hits[kind]++;
      end
    end
    fail_count <= errs;
    pending    <= due_colours.size();
    checked    <= seen;
    n_bg_only  <= kind_hits[BG_ONLY];
    n_plain    <= kind_hits[PLAIN_MIX];
    n_blurred  <= kind_hits[BLUR_MIX];
  end

endmodule

### bench/tb.sv
// testbench top: drives windows and configuration, stalls the output, gives the verdict
`timescale 1ns / 1ps

module tb;
  import ssaa_pkg::*;

  localparam int LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic cfg_index;
  logic [23:0] cfg_data;
  logic in_valid;
  logic in_ready;
  pix_t top_left, top_mid, top_right, mid_left, centre, mid_right;
  pix_t bot_left, bot_mid, bot_right, previous_out;
  logic out_valid;
  logic out_ready;
  pix_t out_colour;

  int fail_count, pending, checked, n_bg_only, n_plain, n_blurred;
  int cycles;
  int settings_used;
  bit no_idle;
  bit hold_req;
  pix_t key;
  pix_t win [9];
  pix_t prev_pix;

  supersample_antialias_downsample_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .top_left(top_left), .top_mid(top_mid), .top_right(top_right),
    .mid_left(mid_left), .centre(centre), .mid_right(mid_right),
    .bot_left(bot_left), .bot_mid(bot_mid), .bot_right(bot_right),
    .previous_out(previous_out),
    .out_valid(out_valid), .out_ready(out_ready), .out_colour(out_colour)
  );

  ssaa_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .top_left(top_left), .top_mid(top_mid), .top_right(top_right),
    .mid_left(mid_left), .centre(centre), .mid_right(mid_right),
    .bot_left(bot_left), .bot_mid(bot_mid), .bot_right(bot_right),
    .previous_out(previous_out),
    .out_valid(out_valid), .out_ready(out_ready), .out_colour(out_colour),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .n_bg_only(n_bg_only), .n_plain(n_plain), .n_blurred(n_blurred)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t pick_pixel(input pix_t k);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return k;
    if (r < 50) return k ^ (24'h1 << $urandom_range(0, 23));
    if (r < 55) return 24'h000000;
    if (r < 60) return 24'hFFFFFF;
    return pix_t'($urandom());
  endfunction

  function automatic pix_t pick_prev(input pix_t k);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return k;
    if (r < 25) return k ^ (pix_t'($urandom()) & 24'h030303);
    if (r < 32) return k ^ (pix_t'($urandom()) & 24'hFFFFFF | 24'h040000);
    if (r < 36) return 24'h000000;
    if (r < 40) return 24'hFFFFFF;
    return pix_t'($urandom());
  endfunction

  task automatic fill_window(input pix_t p);
    int i;
    for (i = 0; i < 9; i++) win[i] = p;
  endtask

  // offer one request, wait for it to be taken, then maybe idle
  task automatic send_window();
    int gap;
    top_left <= win[0];
    top_mid <= win[1];
    top_right <= win[2];
    mid_left <= win[3];
    centre <= win[4];
    mid_right <= win[5];
    bot_left <= win[6];
    bot_mid <= win[7];
    bot_right <= win[8];
    previous_out <= prev_pix;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // waits for the pipeline to empty, then writes both registers
  task automatic set_config(input pix_t bg, input bit blur);
    in_valid <= 1'b0;
    // let the count see a request taken at this very edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    key = bg;
    cfg_wen <= 1'b1;
    cfg_index <= REG_BACKGROUND;
    cfg_data <= bg;
    @(posedge clk);
    cfg_index <= REG_BLUR;
    cfg_data <= {23'd0, blur};
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // receiver: random stalls, idle-free stretches and one long hold
  initial begin
    int run_len;
    int stall;
    out_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        run_len = $urandom_range(1, 20);
        repeat (run_len) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int ph;
    int k;
    int i;
    pix_t bg;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= REG_BACKGROUND;
    cfg_data <= '0;
    in_valid <= 1'b0;
    top_left <= '0;
    top_mid <= '0;
    top_right <= '0;
    mid_left <= '0;
    centre <= '0;
    mid_right <= '0;
    bot_left <= '0;
    bot_mid <= '0;
    bot_right <= '0;
    previous_out <= '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    settings_used = 0;
    key = '0;
    prev_pix = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: plain blending
    set_config(24'hA5C35A, 1'b0);
    fill_window(key);
    send_window();
    fill_window(24'hFFFFFF);
    send_window();
    fill_window(24'h000000);
    send_window();
    fill_window(key);
    win[4] = 24'hFFFFFF;
    send_window();
    fill_window(key);
    win[0] = key ^ 24'h000001;
    win[8] = key ^ 24'h800000;
    send_window();

    // directed: blur mode, background only, near and far old pixel
    set_config(24'hA5C35A, 1'b1);
    fill_window(key);
    prev_pix = 24'hFFFFFF;
    send_window();
    prev_pix = 24'h000000;
    send_window();
    win[1] = 24'h000000;
    win[4] = 24'hFFFFFF;
    prev_pix = key ^ 24'h030303;
    send_window();
    prev_pix = key ^ 24'h040404;
    send_window();
    fill_window(24'hFFFFFF);
    prev_pix = 24'hFFFFFF;
    send_window();
    fill_window(24'h000000);
    prev_pix = 24'h000000;
    send_window();

    // directed: white key with blur
    set_config(24'hFFFFFF, 1'b1);
    fill_window(24'hFFFFFF);
    prev_pix = 24'h000000;
    send_window();
    win[4] = 24'h000000;
    prev_pix = 24'hFFFFFF;
    send_window();
    prev_pix = 24'h000000;
    send_window();

    // directed: black key, blur off
    set_config(24'h000000, 1'b0);
    fill_window(24'h000000);
    send_window();
    win[2] = 24'hFFFFFF;
    send_window();
    fill_window(24'hFFFFFF);
    send_window();

    // random phases, black and white keys first, then random keys
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0) bg = 24'h000000;
      else if (ph == 1) bg = 24'hFFFFFF;
      else bg = pix_t'($urandom());
      set_config(bg, ph[0]);
      no_idle = (ph == 4);
      for (k = 0; k < 255; k++) begin
        if (ph == 2 && k == 50) hold_req = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          fill_window(key);
        end else begin
          for (i = 0; i < 9; i++) win[i] = pick_pixel(key);
        end
        prev_pix = pick_prev(key);
        send_window();
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d pixels checked over %0d register settings", checked, settings_used);
    $display("%0d background-only, %0d plain blends, %0d mixed with the old pixel",
             n_bg_only, n_plain, n_blurred);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
